/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
package spq_pkg;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Width of the reported occupancy field
  localparam int unsigned OCC_W = 7;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
module spq_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk_i,
  input  spq_pkg::spq_op_t    op_i,
  input  logic                occupied_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                left_keep_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  output logic                keep_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // An occupied entry with key no greater than the new one stays in place.
  assign keep_o = occupied_i && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    priority if (op_i.rem) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end else if (op_i.ins && !keep_o) begin
      if (left_keep_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end else begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

/* sv/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Sorted min-first priority queue built as a row of compare-and-shift cells.
// The result strobe done_o rises in the cycle after start_i is taken.
// Throughput: one item per cycle; busy_o stays low, as every cell decides
// from one broadcast compare against its own entry.
// Reset clears the entry count and the result strobe; stored entries are not
// cleared. The receiver cannot stall: each result's strobe shows for one cycle only.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [TAG_BITS-1:0]           tag_i,
  output logic                          done_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic [KEY_BITS-1:0]           out_key_o,
  output logic [TAG_BITS-1:0]           out_tag_o,
  output logic [spq_pkg::OCC_W-1:0]     occupancy_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Entry count and registered result
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         done_q;
  logic [spq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [KEY_BITS-1:0]          out_key_q, out_key_d;
  logic [TAG_BITS-1:0]          out_tag_q, out_tag_d;

  logic             accept;
  logic             is_full;
  logic             is_empty;
  spq_pkg::spq_op_t op;

  // Cell row taps
  logic [QUEUE_DEPTH-1:0] keep;
  logic [QUEUE_DEPTH-1:0] occupied;
  logic [KEY_BITS-1:0]    cell_key [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    cell_tag [QUEUE_DEPTH];

  // busy_o is tied low, so the block never holds off start.
  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);

  // Drop an insert into a full queue and a remove from an empty one.
  assign op.ins = accept && (req_type_i == spq_pkg::REQ_INSERT) && !is_full;
  assign op.rem = accept && (req_type_i == spq_pkg::REQ_REMOVE) && !is_empty;

  // Build the row: each cell looks left on insert and right on remove.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                left_keep;
    logic [KEY_BITS-1:0] left_key;
    logic [TAG_BITS-1:0] left_tag;
    logic [KEY_BITS-1:0] right_key;
    logic [TAG_BITS-1:0] right_tag;

    assign occupied[i] = (IDX < count_q);

    if (i == 0) begin : g_head
      // The head has nothing to its left: a new entry lands here if needed.
      assign left_keep = 1'b1;
      assign left_key  = key_i;
      assign left_tag  = tag_i;
    end else begin : g_body
      assign left_keep = keep[i-1];
      assign left_key  = cell_key[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // The tail falls out of range on remove; its content no longer counts.
      assign right_key = cell_key[i];
      assign right_tag = cell_tag[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_tag = cell_tag[i+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS),
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .occupied_i (occupied[i]),
      .new_key_i  (key_i),
      .new_tag_i  (tag_i),
      .left_keep_i(left_keep),
      .left_key_i (left_key),
      .left_tag_i (left_tag),
      .right_key_i(right_key),
      .right_tag_i(right_tag),
      .keep_o     (keep[i]),
      .key_o      (cell_key[i]),
      .tag_o      (cell_tag[i])
    );
  end

  // Work out the count and the result of the accepted item.
  always_comb begin
    count_d   = count_q;
    status_d  = spq_pkg::ST_OK;
    out_key_d = '0;
    out_tag_d = '0;
    if (accept) begin
      if (req_type_i == spq_pkg::REQ_INSERT) begin
        if (is_full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          // Head cell holds the smallest key, oldest first among equals.
          out_key_d = cell_key[0];
          out_tag_d = cell_tag[0];
          count_d   = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Hold the result payload; only the strobe needs reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_tag_q <= out_tag_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign occupancy_o = spq_pkg::OCC_W'(count_q);

endmodule
